// File: hw/rtl/mpo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_pkg: shared types and constants of the P&O tracker
// Field widths, register reset values, command codes, sequencer states and
// the request/response bundles of the shared divider.
// ----------------------------------------------------------------------------
package mpo_pkg;

    localparam int DUTY_W  = 8;
    localparam int VOLT_W  = 16;
    localparam int CURR_W  = 12;
    localparam int POWER_W = 28;
    localparam int STEP_W  = 7;
    localparam int AVG_W   = 7;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;
    localparam int VSUM_W  = 22;
    localparam int CSUM_W  = 18;

    // The divider walks the full width of the wider running sum.
    localparam int DIV_STEPS = VSUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
    localparam logic [AVG_W-1:0]  MAX_AVG  = 7'd64;

    localparam logic [STEP_W-1:0] STEP_RST  = 7'd1;
    localparam logic [AVG_W-1:0]  AVG_RST   = 7'd4;
    localparam logic [DUTY_W-1:0] START_RST = 8'd10;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_STEP  = 2'd0,
        CFG_AVG   = 2'd1,
        CFG_START = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_V,
        ST_DIV_V,
        ST_LOAD_C,
        ST_DIV_C,
        ST_MUL,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [VSUM_W-1:0] dividend;
        logic [AVG_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [VSUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: hw/rtl/mpo_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_in_if: command and sample channel
// Valid/ready channel carrying a start command or one voltage/current sample.
// ----------------------------------------------------------------------------
interface mpo_in_if import mpo_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [VOLT_W-1:0] voltage_mv;
    logic [CURR_W-1:0] current_ma;

    modport source (output valid, output cmd, output voltage_mv, output current_ma,
                    input ready);
    modport sink   (input valid, input cmd, input voltage_mv, input current_ma,
                    output ready);

endinterface

// File: hw/rtl/mpo_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_out_if: tracking decision channel
// Valid/ready channel carrying the new duty, batch power and step direction.
// ----------------------------------------------------------------------------
interface mpo_out_if import mpo_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  duty;
    logic [POWER_W-1:0] avg_power;
    logic               went_up;

    modport source (output valid, output duty, output avg_power, output went_up,
                    input ready);
    modport sink   (input valid, input duty, input avg_power, input went_up,
                    output ready);

endinterface

// File: hw/rtl/mppt_perturb_observe_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_perturb_observe_top: perturb-and-observe maximum power point tracker
// Accumulates voltage/current samples, averages each batch through a shared
// divider, forms the batch power and steps the PWM duty toward more power.
//
//   Channel   Dir   Beat contents
//   i_in      in    cmd, voltage_mv, current_ma
//   o_res     out   duty, avg_power, went_up
//   i_cfg_*   in    register index and write data, no handshake
//
// A start command or a sample that completes no batch leaves the sequencer idle.
// A sample that completes a batch runs two divider passes (load, one step per
// bit of the 22-bit running sum, done), then one multiply and one decision.
// While that work runs, or while a result beat waits to be taken, i_in is not
// ready. Reset is synchronous and clears history and registers.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_top import mpo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mpo_in_if.sink            i_in,
    mpo_out_if.source         o_res,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_state              r_state, n_state;

    logic [STEP_W-1:0]   r_step;
    logic [AVG_W-1:0]    r_avg;
    logic [DUTY_W-1:0]   r_start;

    logic [DUTY_W-1:0]   r_duty_now;
    logic [DUTY_W-1:0]   r_duty_before;
    logic [POWER_W-1:0]  r_power_before;
    logic [VSUM_W-1:0]   r_vsum;
    logic [CSUM_W-1:0]   r_csum;
    logic [AVG_W-1:0]    r_count;

    // A batch cut short by a lower count can average above the field range,
    // so the averages keep the width of the sums.
    logic [VSUM_W-1:0]   r_avg_v;
    logic [CSUM_W-1:0]   r_avg_c;
    logic [POWER_W-1:0]  r_power;

    logic                r_out_valid;
    logic [DUTY_W-1:0]   r_out_duty;
    logic [POWER_W-1:0]  r_out_power;
    logic                r_out_up;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    logic                w_in_fire;
    logic                w_out_free;
    logic                w_commit;
    logic [VOLT_W-1:0]   w_v_adj;
    logic [CURR_W-1:0]   w_c_adj;
    logic [AVG_W-1:0]    w_batch_len;
    logic [AVG_W-1:0]    w_count_inc;
    logic                w_batch_end;
    logic                w_dir_prev;
    logic                w_up;
    logic [DUTY_W:0]     w_duty_sum;
    logic [DUTY_W-1:0]   w_next_duty;
    logic [VSUM_W+CSUM_W-1:0] w_product;

    mpo_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && (r_state == ST_IDLE) && w_out_free;

    // A zero reading counts as one.
    assign w_v_adj = (i_in.voltage_mv == '0) ? VOLT_W'(1) : i_in.voltage_mv;
    assign w_c_adj = (i_in.current_ma == '0) ? CURR_W'(1) : i_in.current_ma;

    always_comb begin
        if (r_avg == '0) begin
            w_batch_len = AVG_W'(1);
        end else if (r_avg > MAX_AVG) begin
            w_batch_len = MAX_AVG;
        end else begin
            w_batch_len = r_avg;
        end
    end

    assign w_count_inc = r_count + 1'b1;
    assign w_batch_end = (w_count_inc >= w_batch_len);

    // The last step counts as upward unless the duty went down; a power drop
    // reverses it.
    assign w_dir_prev = !(r_duty_before > r_duty_now);
    assign w_up       = (r_power_before > r_power) ? !w_dir_prev : w_dir_prev;
    assign w_duty_sum = {1'b0, r_duty_now} + {2'b00, r_step};

    assign w_product = {{CSUM_W{1'b0}}, r_avg_v} * {{VSUM_W{1'b0}}, r_avg_c};

    always_comb begin
        if (w_up) begin
            if (w_duty_sum > {1'b0, DUTY_MAX}) begin
                w_next_duty = DUTY_MAX;
            end else begin
                w_next_duty = w_duty_sum[DUTY_W-1:0];
            end
        end else begin
            if ({1'b0, r_step} > r_duty_now) begin
                w_next_duty = '0;
            end else begin
                w_next_duty = r_duty_now - {1'b0, r_step};
            end
        end
    end

    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_vsum;
        w_div_req.divisor  = w_batch_len;
        w_commit           = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && (i_in.cmd == CMD_SAMPLE) && w_batch_end) begin
                    n_state = ST_LOAD_V;
                end
            end
            ST_LOAD_V: begin
                w_div_req.start = 1'b1;
                n_state         = ST_DIV_V;
            end
            ST_DIV_V: begin
                if (w_div_rsp.done) begin
                    n_state = ST_LOAD_C;
                end
            end
            ST_LOAD_C: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {{(VSUM_W-CSUM_W){1'b0}}, r_csum};
                n_state            = ST_DIV_C;
            end
            ST_DIV_C: begin
                if (w_div_rsp.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_step         <= STEP_RST;
            r_avg          <= AVG_RST;
            r_start        <= START_RST;
            r_duty_now     <= '0;
            r_duty_before  <= '0;
            r_power_before <= '0;
            r_vsum         <= '0;
            r_csum         <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_AVG:   r_avg   <= i_cfg_data[AVG_W-1:0];
                    CFG_START: r_start <= i_cfg_data[DUTY_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_in_fire) begin
                if (i_in.cmd == CMD_START) begin
                    r_duty_now     <= r_start;
                    r_duty_before  <= r_start;
                    r_power_before <= '0;
                    r_vsum         <= '0;
                    r_csum         <= '0;
                    r_count        <= '0;
                    r_out_valid    <= 1'b1;
                end else begin
                    r_vsum  <= r_vsum + {{(VSUM_W-VOLT_W){1'b0}}, w_v_adj};
                    r_csum  <= r_csum + {{(CSUM_W-CURR_W){1'b0}}, w_c_adj};
                    r_count <= w_count_inc;
                end
            end

            if (w_commit) begin
                r_duty_before  <= r_duty_now;
                r_duty_now     <= w_next_duty;
                r_power_before <= r_power;
                r_vsum         <= '0;
                r_csum         <= '0;
                r_count        <= '0;
                r_out_valid    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DIV_V) && w_div_rsp.done) begin
            r_avg_v <= w_div_rsp.quotient;
        end
        if ((r_state == ST_DIV_C) && w_div_rsp.done) begin
            r_avg_c <= w_div_rsp.quotient[CSUM_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_power <= w_product[POWER_W-1:0];
        end

        if (w_in_fire && (i_in.cmd == CMD_START)) begin
            r_out_duty  <= r_start;
            r_out_power <= '0;
            r_out_up    <= 1'b0;
        end else if (w_commit) begin
            r_out_duty  <= w_next_duty;
            r_out_power <= r_power;
            r_out_up    <= w_up;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.duty      = r_out_duty;
    assign o_res.avg_power = r_out_power;
    assign o_res.went_up   = r_out_up;

endmodule

// File: hw/rtl/mpo_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_divider: shared restoring divider
// One quotient bit per cycle over the width of the running sum; the sequencer
// uses it first for the voltage average and then for the current average.
// ----------------------------------------------------------------------------
module mpo_divider import mpo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [VSUM_W-1:0] r_quo;
    logic [AVG_W-1:0]  r_rem;
    logic [AVG_W-1:0]  r_div;

    logic [AVG_W:0]    w_shift;
    logic [AVG_W:0]    w_diff;
    logic              w_fits;

    assign w_shift = {r_rem, r_quo[VSUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fits  = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= w_diff[AVG_W-1:0];
                r_quo <= {r_quo[VSUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[AVG_W-1:0];
                r_quo <= {r_quo[VSUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: hw/rtl/mpo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpo_checker: port-level checks of the P&O tracker
// Watches the two channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module mpo_checker import mpo_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_cmd,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DUTY_W-1:0]  i_out_duty,
    input logic [POWER_W-1:0] i_out_avg_power,
    input logic               i_out_went_up
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_duty) && $stable(i_out_avg_power)
            && $stable(i_out_went_up))
        else $error("result beat changed while stalled");

    // No new item may enter while a result beat cannot leave.
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input ready while result beat is blocked");

    // A start command answers on the next cycle with zero power and no upward step.
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_START) |=>
            i_out_valid && (i_out_avg_power == '0) && !i_out_went_up)
        else $error("start command did not give its result beat");

endmodule

bind mppt_perturb_observe_top mpo_checker u_mpo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_cmd        (i_in.cmd),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_duty      (o_res.duty),
    .i_out_avg_power (o_res.avg_power),
    .i_out_went_up   (o_res.went_up)
);

// File: sim/mppt_perturb_observe_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_perturb_observe_top_tb: self-checking bench for the P&O tracker
// Sends start commands and voltage/current samples and keeps a behavioral
// copy of the tracker that works out each expected decision. Result beats
// are checked in order. Register settings change between phases, the input
// channel sees random gaps and the result channel random stalls.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_top_tb;
    import mpo_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS   = 50;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [POWER_W-1:0] avg_power;
        logic               went_up;
    } t_decision;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx  = CFG_STEP;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    mpo_in_if  in_if ();
    mpo_out_if res_if ();

    mppt_perturb_observe_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Tracker copy: registers and tracking history.
    logic [STEP_W-1:0]  step_reg;
    logic [AVG_W-1:0]   avg_reg;
    logic [DUTY_W-1:0]  start_reg;
    logic [DUTY_W-1:0]  duty_now;
    logic [DUTY_W-1:0]  duty_prev;
    logic [POWER_W-1:0] power_prev;
    logic [VSUM_W-1:0]  volt_sum;
    logic [CSUM_W-1:0]  curr_sum;
    logic [AVG_W-1:0]   batch_fill;

    t_decision   pending_decisions[$];
    int          mismatches = 0;
    int          cycle_cnt  = 0;
    bit          gaps_on    = 1'b0;
    bit          stalls_on  = 1'b0;
    int unsigned stall_left = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned pick_pause();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic int unsigned pick_gap();
        if (!gaps_on || $urandom_range(0, 99) < 55) begin
            return 0;
        end
        return pick_pause();
    endfunction

    function automatic logic [VOLT_W-1:0] draw_volt();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return VOLT_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CURR_W-1:0] draw_curr();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return CURR_W'($urandom_range(0, 4095));
    endfunction

    function automatic void reset_tracker();
        step_reg   = STEP_RST;
        avg_reg    = AVG_RST;
        start_reg  = START_RST;
        duty_now   = '0;
        duty_prev  = '0;
        power_prev = '0;
        volt_sum   = '0;
        curr_sum   = '0;
        batch_fill = '0;
    endfunction

    // Works out the decision, if any, that one accepted beat causes.
    function automatic void track_beat(input logic cmd, input logic [VOLT_W-1:0] volt,
                                       input logic [CURR_W-1:0] curr);
        logic [AVG_W-1:0]         batch_len;
        logic [VSUM_W-1:0]        avg_volt;
        logic [CSUM_W-1:0]        avg_curr;
        logic [VSUM_W+CSUM_W-1:0] product;
        logic [POWER_W-1:0]       power;
        logic                     up;
        int                       next_duty;
        if (cmd == CMD_START) begin
            duty_now   = start_reg;
            duty_prev  = start_reg;
            power_prev = '0;
            volt_sum   = '0;
            curr_sum   = '0;
            batch_fill = '0;
            pending_decisions.push_back(t_decision'{start_reg, '0, 1'b0});
            return;
        end
        // Zero readings count as 1.
        volt_sum   = volt_sum + VSUM_W'((volt == '0) ? VOLT_W'(1) : volt);
        curr_sum   = curr_sum + CSUM_W'((curr == '0) ? CURR_W'(1) : curr);
        batch_fill = batch_fill + 1'b1;

        if (avg_reg == '0) begin
            batch_len = AVG_W'(1);
        end else if (avg_reg > MAX_AVG) begin
            batch_len = MAX_AVG;
        end else begin
            batch_len = avg_reg;
        end
        if (batch_fill < batch_len) begin
            return;
        end

        // A batch shortened midway can average above the field range, so the
        // averages keep the width of the sums and the power wraps at 28 bits.
        avg_volt = volt_sum / batch_len;
        avg_curr = curr_sum / batch_len;
        product  = avg_volt * avg_curr;
        power    = product[POWER_W-1:0];

        up = !(duty_prev > duty_now);
        if (power_prev > power) begin
            up = !up;
        end
        next_duty = up ? int'(duty_now) + int'(step_reg) : int'(duty_now) - int'(step_reg);
        if (next_duty < 0) begin
            next_duty = 0;
        end else if (next_duty > int'(DUTY_MAX)) begin
            next_duty = int'(DUTY_MAX);
        end

        duty_prev  = duty_now;
        duty_now   = DUTY_W'(next_duty);
        power_prev = power;
        volt_sum   = '0;
        curr_sum   = '0;
        batch_fill = '0;
        pending_decisions.push_back(t_decision'{duty_now, power, up});
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch in %s: expected %0d, got %0d", field, want, got);
            end
        end
    endfunction

    // Result sink with random back-pressure.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            stall_left   <= pick_pause() - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_decision want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result beat: duty %0d, power %0d, up %0d",
                             res_if.duty, res_if.avg_power, res_if.went_up);
                end
            end else begin
                want = pending_decisions.pop_front();
                compare_field("duty", 32'(want.duty), 32'(res_if.duty));
                compare_field("avg_power", 32'(want.avg_power), 32'(res_if.avg_power));
                compare_field("went_up", 32'(want.went_up), 32'(res_if.went_up));
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [VOLT_W-1:0] volt,
                             input logic [CURR_W-1:0] curr);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.cmd        <= cmd;
        in_if.voltage_mv <= volt;
        in_if.current_ma <= curr;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        track_beat(cmd, volt, curr);
    endtask

    // Samples that end no batch give no result, so the tail wait covers a
    // batch that may still be in the divider.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_STEP:  step_reg  = data[STEP_W-1:0];
            CFG_AVG:   avg_reg   = data[AVG_W-1:0];
            CFG_START: start_reg = data;
            default: ;
        endcase
    endtask

    // Tracking from the reset duty before any start, with zero readings.
    task automatic test_pre_start_tracking();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_beat(CMD_SAMPLE, 16'd0, 12'd0);
        send_beat(CMD_SAMPLE, 16'hFFFF, 12'hFFF);
        send_beat(CMD_SAMPLE, 16'd0, 12'hFFF);
        send_beat(CMD_SAMPLE, 16'hFFFF, 12'd0);
        settle();
    endtask

    // Direction keeping and reversal, clamping at both ends, zero step.
    task automatic test_direction_and_clamp();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        write_reg(CFG_AVG, 8'd1);
        write_reg(CFG_STEP, 8'd64);
        write_reg(CFG_START, 8'd200);
        send_beat(CMD_START, 16'd0, 12'd0);
        send_beat(CMD_SAMPLE, 16'd1000, 12'd1000);
        send_beat(CMD_SAMPLE, 16'd1000, 12'd1000);
        send_beat(CMD_SAMPLE, 16'd10, 12'd10);
        settle();
        write_reg(CFG_START, 8'd30);
        send_beat(CMD_START, 16'hFFFF, 12'hFFF);
        send_beat(CMD_SAMPLE, 16'd60000, 12'd4000);
        send_beat(CMD_SAMPLE, 16'd100, 12'd100);
        send_beat(CMD_SAMPLE, 16'd100, 12'd100);
        send_beat(CMD_SAMPLE, 16'd100, 12'd100);
        settle();
        write_reg(CFG_STEP, 8'd0);
        send_beat(CMD_SAMPLE, 16'd100, 12'd100);
        send_beat(CMD_SAMPLE, 16'd50, 12'd50);
        settle();
    endtask

    // Batch length of zero, and a batch cut short by lowering the count.
    task automatic test_batch_length();
        gaps_on   = 1'b1;
        stalls_on = 1'b0;
        write_reg(CFG_STEP, 8'd5);
        write_reg(CFG_AVG, 8'd0);
        send_beat(CMD_SAMPLE, 16'hFFFF, 12'hFFF);
        settle();
        write_reg(CFG_AVG, 8'd6);
        send_beat(CMD_START, 16'd0, 12'd0);
        send_beat(CMD_SAMPLE, 16'hFFFF, 12'hFFF);
        send_beat(CMD_SAMPLE, 16'hFFFF, 12'hFFF);
        send_beat(CMD_SAMPLE, 16'hFFFF, 12'hFFF);
        settle();
        write_reg(CFG_AVG, 8'd2);
        send_beat(CMD_SAMPLE, 16'hFFFF, 12'hFFF);
        settle();
    endtask

    task automatic test_random_tracking();
        logic [CFG_W-1:0] step_val;
        logic [CFG_W-1:0] avg_val;
        logic [CFG_W-1:0] start_val;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            gaps_on   = (phase % 3) != 0;
            stalls_on = (phase % 4) != 1;
            case ($urandom_range(0, 5))
                0:       step_val = 8'd0;
                1:       step_val = 8'd1;
                2:       step_val = 8'd64;
                3:       step_val = 8'd127;
                default: step_val = CFG_W'($urandom_range(1, 64));
            endcase
            // Long batches only in a few phases to keep decisions frequent.
            if (phase == 0) begin
                avg_val = 8'd0;
            end else if (phase == 3) begin
                avg_val = 8'd127;
            end else if (phase == 7) begin
                avg_val = 8'd64;
            end else begin
                avg_val = CFG_W'($urandom_range(1, 8));
            end
            case ($urandom_range(0, 3))
                0:       start_val = 8'd0;
                1:       start_val = 8'd255;
                default: start_val = CFG_W'($urandom_range(0, 255));
            endcase
            write_reg(CFG_STEP, step_val);
            write_reg(CFG_AVG, avg_val);
            write_reg(CFG_START, start_val);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if ((k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 99) < 4) begin
                    send_beat(CMD_START, draw_volt(), draw_curr());
                end else begin
                    send_beat(CMD_SAMPLE, draw_volt(), draw_curr());
                end
            end
        end
    endtask

    initial begin
        in_if.valid      = 1'b0;
        in_if.cmd        = CMD_SAMPLE;
        in_if.voltage_mv = '0;
        in_if.current_ma = '0;
        res_if.ready     = 1'b0;
        reset_tracker();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pre_start_tracking();
        test_direction_and_clamp();
        test_batch_length();
        test_random_tracking();
        settle();

        if (mismatches == 0 && pending_decisions.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mpo_pkg.sv
hw/rtl/mpo_in_if.sv
hw/rtl/mpo_out_if.sv
hw/rtl/mpo_divider.sv
hw/rtl/mppt_perturb_observe_top.sv
hw/rtl/mpo_checker.sv
sim/mppt_perturb_observe_top_tb.sv
